// ===== sv/ilr_pkg.sv =====
// Shared types and constants for the interpolated line rasterizer.
// No dependencies; imported by every module of the block.
package ilr_pkg;

    // Coordinate width fixed by the transaction format
    localparam int COORD_W = 7;
    // Quotient bits produced by the setup divider, one per cycle
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // One line command
    typedef struct packed {
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] end_col;
    } t_line_cmd;

    // One result: two dots of the line
    typedef struct packed {
        logic [COORD_W-1:0] dot_a_row;
        logic [COORD_W-1:0] dot_a_col;
        logic [COORD_W-1:0] dot_b_row;
        logic [COORD_W-1:0] dot_b_col;
        logic               dot_b_valid;
        logic               last_pair;
    } t_dot_pair;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture endpoints and set up the divider
        logic div_step;   // one restoring-division step
        logic div_last;   // final division step; also clears the walk state
        logic step;       // produce one dot and advance
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic at_last;    // current dot is the line's end point
    } t_dp_stat;

endpackage

// ===== sv/ilr_ctrl.sv =====
// Sequencer for the line rasterizer: idle, divide setup, dot walk.
// Depends on ilr_pkg for the command and status structs.
module ilr_ctrl
    import ilr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;

    localparam logic [DIV_CNT_W-1:0] CNT_INIT = DIV_CNT_W'(DIV_STEPS - 1);

    logic [1:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    assign busy = (r_state != ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_INIT;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = ST_WALK;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_stat.at_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/ilr_dp.sv =====
// Datapath for the line rasterizer: endpoint setup, serial divider,
// incremental quotient walk and dot pairing. Depends on ilr_pkg.
module ilr_dp
    import ilr_pkg::*;
#(
    parameter int COORD_MAX = 127
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_line_cmd i_line,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_strobe,
    output t_dot_pair o_result
);

    localparam logic [COORD_W-1:0] MAX_C = COORD_W'(COORD_MAX);

    function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
        clamp = (v > MAX_C) ? MAX_C : v;
    endfunction

    // Endpoint setup (combinational, captured on load)
    logic [COORD_W-1:0] r1, c1, r2, c2;
    logic               row_major;
    logic [COORD_W-1:0] maj_s, maj_e, min_s, min_e;

    always_comb begin
        r1        = clamp(i_line.start_row);
        c1        = clamp(i_line.start_col);
        r2        = clamp(i_line.end_row);
        c2        = clamp(i_line.end_col);
        row_major = (r1 != r2);
        maj_s     = row_major ? r1 : c1;
        maj_e     = row_major ? r2 : c2;
        min_s     = row_major ? c1 : r1;
        min_e     = row_major ? c2 : r2;
    end

    // Line geometry
    logic               r_row_major;
    logic               r_maj_dn;
    logic [COORD_W-1:0] r_maj, r_maj_end;
    logic               r_min_neg;
    logic [COORD_W-1:0] r_min_base;
    logic [COORD_W-1:0] r_run;

    // Divider: span / run
    logic [COORD_W-1:0] r_dvd, r_prem, r_quo;
    logic [COORD_W:0]   div_trial;
    logic               div_ge;

    assign div_trial = {r_prem, r_dvd[COORD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_run});

    // Walk accumulators: floor(i * span / run) and its remainder
    logic [COORD_W-1:0] r_acc_q, r_acc_r;
    logic [COORD_W:0]   sum_r;
    logic               rem_wrap;
    logic [COORD_W-1:0] cur_min, cur_row, cur_col;

    assign sum_r    = {1'b0, r_acc_r} + {1'b0, r_prem};
    assign rem_wrap = (sum_r >= {1'b0, r_run});
    assign cur_min  = r_min_neg ? (r_min_base - r_acc_q) : (r_min_base + r_acc_q);
    assign cur_row  = r_row_major ? r_maj : cur_min;
    assign cur_col  = r_row_major ? cur_min : r_maj;

    assign o_stat.at_last = (r_maj == r_maj_end);

    // Geometry, divider and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row_major <= row_major;
            r_maj       <= maj_s;
            r_maj_end   <= maj_e;
            r_maj_dn    <= (maj_e < maj_s);
            r_run       <= (maj_e < maj_s) ? (maj_s - maj_e) : (maj_e - maj_s);
            r_min_base  <= min_s;
            r_min_neg   <= (min_e < min_s);
            r_dvd       <= (min_e < min_s) ? (min_s - min_e) : (min_e - min_s);
            r_prem      <= '0;
            r_quo       <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[COORD_W-2:0], 1'b0};
            r_prem <= div_ge ? COORD_W'(div_trial - {1'b0, r_run}) : div_trial[COORD_W-1:0];
            r_quo  <= {r_quo[COORD_W-2:0], div_ge};
        end
        if (i_cmd.div_last) begin
            r_acc_q <= '0;
            r_acc_r <= '0;
        end
        if (i_cmd.step) begin
            r_maj   <= r_maj_dn ? (r_maj - 1'b1) : (r_maj + 1'b1);
            r_acc_r <= rem_wrap ? COORD_W'(sum_r - {1'b0, r_run}) : sum_r[COORD_W-1:0];
            r_acc_q <= r_acc_q + r_quo + COORD_W'(rem_wrap);
        end
    end

    // Dot pairing: hold the earlier dot, emit on the later one or at line end
    logic               r_phase;
    logic [COORD_W-1:0] r_a_row, r_a_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.step & (r_phase | o_stat.at_last);
            if (i_cmd.div_last) begin
                r_phase <= 1'b0;
            end
            if (i_cmd.step) begin
                r_phase <= ~r_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            if (!r_phase) begin
                r_a_row              <= cur_row;
                r_a_col              <= cur_col;
                o_result.dot_a_row   <= cur_row;
                o_result.dot_a_col   <= cur_col;
                o_result.dot_b_row   <= '0;
                o_result.dot_b_col   <= '0;
                o_result.dot_b_valid <= 1'b0;
                o_result.last_pair   <= 1'b1;
            end else begin
                o_result.dot_a_row   <= r_a_row;
                o_result.dot_a_col   <= r_a_col;
                o_result.dot_b_row   <= cur_row;
                o_result.dot_b_col   <= cur_col;
                o_result.dot_b_valid <= 1'b1;
                o_result.last_pair   <= o_stat.at_last;
            end
        end
    end

endmodule

// ===== sv/interpolated_line_rasterizer.sv =====
// Top level of the interpolated line rasterizer.
// Depends on ilr_pkg, ilr_ctrl and ilr_dp.
//
// A line command is taken when start is high and busy is low. After a
// serial division of the minor span by the major run, the walk produces
// one dot per cycle; busy stays high through the division and the walk,
// and a new command can be taken in the first cycle with busy low. Dots
// come out two per transaction on o_result, marked by a one-cycle o_strobe,
// one for each pair of dots in the walk; a lone final dot of an odd line
// follows the pair before it in the next cycle, and the final transaction
// shows in the first cycle with busy low. The receiver cannot stall and
// must take each transaction as it appears.
// Coordinates above COORD_MAX are saturated to COORD_MAX.
module interpolated_line_rasterizer
    import ilr_pkg::*;
#(
    parameter int COORD_MAX = 127
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_line_cmd i_line,
    output logic      o_strobe,
    output t_dot_pair o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    ilr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // Arithmetic and output register
    ilr_dp #(
        .COORD_MAX (COORD_MAX)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_line   (i_line),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== sv/ilr_checker.sv =====
// Port-level checks for the interpolated line rasterizer.
// Depends on ilr_pkg; bound to interpolated_line_rasterizer below.
module ilr_checker
    import ilr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_dot_pair o_result
);

    // Reset leaves no transaction pending
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

    // An accepted command makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("command accepted but block not busy");

    // A half-filled pair only closes a line
    a_half_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.dot_b_valid |-> o_result.last_pair)
        else $error("single-dot transaction not marked last");

    // More dots follow only while busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_pair |-> busy)
        else $error("non-final transaction while idle");

    // Nothing follows a line's final transaction in the next cycle
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_pair |=> !o_strobe)
        else $error("transaction right after a line end");

endmodule

bind interpolated_line_rasterizer ilr_checker u_ilr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for interpolated_line_rasterizer: predicts every dot pair
// of each line command and checks each strobed transaction. Depends on ilr_pkg.
module tb_top;
    import ilr_pkg::*;

    localparam int COORD_LIMIT = 127;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 140;
    localparam int RANDOM_LINES = 300;
    localparam int LINE_W = $bits(t_line_cmd);

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_line_cmd i_line;
    logic      o_strobe;
    t_dot_pair o_result;

    t_dot_pair expected_pairs[$];
    int        fail_count = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    int        lines_sent = 0;
    int        pairs_checked = 0;
    int        single_dot_lines = 0;
    int        col_major_lines = 0;
    int        odd_lines = 0;
    int        longest_line = 0;

    interpolated_line_rasterizer #(
        .COORD_MAX (COORD_LIMIT)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_line   (i_line),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Saturate a coordinate to the configured maximum
    function automatic int sat_coord(logic [COORD_W-1:0] v);
        return (int'(v) > COORD_LIMIT) ? COORD_LIMIT : int'(v);
    endfunction

    // Walk the line along its major axis and queue the dot pairs it yields
    function automatic void predict_line_dots(t_line_cmd cmd);
        int r1, c1, r2, c2, dir, pos, n, k;
        int rows[COORD_LIMIT+1];
        int cols[COORD_LIMIT+1];
        t_dot_pair pair;
        r1 = sat_coord(cmd.start_row);
        c1 = sat_coord(cmd.start_col);
        r2 = sat_coord(cmd.end_row);
        c2 = sat_coord(cmd.end_col);
        n = 0;
        if (r1 != r2) begin
            dir = (r1 < r2) ? 1 : -1;
            for (pos = r1; n <= COORD_LIMIT; pos += dir) begin
                rows[n] = pos;
                cols[n] = c1 + ((pos - r1) * (c2 - c1)) / (r2 - r1);
                n++;
                if (pos == r2) break;
            end
        end else if (c1 != c2) begin
            col_major_lines++;
            dir = (c1 < c2) ? 1 : -1;
            for (pos = c1; n <= COORD_LIMIT; pos += dir) begin
                cols[n] = pos;
                rows[n] = r1 + ((pos - c1) * (r2 - r1)) / (c2 - c1);
                n++;
                if (pos == c2) break;
            end
        end else begin
            single_dot_lines++;
            rows[0] = r1;
            cols[0] = c1;
            n = 1;
        end
        if (n % 2) odd_lines++;
        if (n > longest_line) longest_line = n;
        // two dots per transaction; a lone final dot leaves dot b zeroed
        for (k = 0; k < n; k += 2) begin
            pair = '0;
            pair.dot_a_row = COORD_W'(rows[k]);
            pair.dot_a_col = COORD_W'(cols[k]);
            if (k + 1 < n) begin
                pair.dot_b_row   = COORD_W'(rows[k+1]);
                pair.dot_b_col   = COORD_W'(cols[k+1]);
                pair.dot_b_valid = 1'b1;
            end
            pair.last_pair = (k + 2 >= n);
            expected_pairs.push_back(pair);
        end
    endfunction

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic string pair_str(t_dot_pair p);
        return $sformatf("a=(%0d,%0d) b=(%0d,%0d) b_valid=%0b last=%0b",
                         p.dot_a_row, p.dot_a_col, p.dot_b_row, p.dot_b_col,
                         p.dot_b_valid, p.last_pair);
    endfunction

    // Compare every strobed transaction with the oldest expected pair
    always @(posedge i_clk) begin : pair_check
        t_dot_pair want;
        if (i_rst_n && o_strobe) begin
            if (expected_pairs.size() == 0) begin
                log_failure({"unexpected transaction ", pair_str(o_result)});
            end else begin
                want = expected_pairs.pop_front();
                pairs_checked++;
                if (o_result.dot_a_row !== want.dot_a_row ||
                    o_result.dot_a_col !== want.dot_a_col ||
                    o_result.dot_b_row !== want.dot_b_row ||
                    o_result.dot_b_col !== want.dot_b_col ||
                    o_result.dot_b_valid !== want.dot_b_valid ||
                    o_result.last_pair !== want.last_pair)
                    log_failure({"expected ", pair_str(want), " got ", pair_str(o_result)});
            end
        end
    end

    // Watchdog: cycles with neither a command nor a result accepted
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles, %0d pairs outstanding",
                     IDLE_LIMIT, expected_pairs.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Send one line command; called just after a falling edge, returns likewise
    task automatic issue_line(t_line_cmd cmd);
        int gap;
        if (burst_left == 0) begin
            start  = 1'b0;
            i_line = t_line_cmd'(LINE_W'($urandom));
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        start  = 1'b1;
        i_line = cmd;
        do @(posedge i_clk); while (busy);
        predict_line_dots(cmd);
        lines_sent++;
        @(negedge i_clk);
    endtask

    task automatic issue_coords(int r1, int c1, int r2, int c2);
        t_line_cmd cmd;
        cmd.start_row = COORD_W'(r1);
        cmd.start_col = COORD_W'(c1);
        cmd.end_row   = COORD_W'(r2);
        cmd.end_col   = COORD_W'(c2);
        issue_line(cmd);
    endtask

    // Hold off the sender until every expected pair has come back
    task automatic wait_for_drain();
        start  = 1'b0;
        burst_left = 0;
        while (expected_pairs.size() != 0) @(negedge i_clk);
    endtask

    function automatic int near_coord(int base);
        int v;
        v = base + $urandom_range(0, 12) - 6;
        return (v < 0) ? 0 : (v > COORD_LIMIT) ? COORD_LIMIT : v;
    endfunction

    // Equal endpoints, at both corners and one interior point
    task automatic test_single_dots();
        issue_coords(0, 0, 0, 0);
        issue_coords(127, 127, 127, 127);
        issue_coords(64, 3, 64, 3);
        wait_for_drain();
    endtask

    // Rows differ: full spans, both directions, odd counts, negative spans
    task automatic test_row_major();
        issue_coords(0, 0, 127, 127);
        issue_coords(127, 127, 0, 0);
        issue_coords(0, 127, 127, 0);
        issue_coords(127, 0, 0, 127);
        issue_coords(0, 0, 127, 0);
        issue_coords(0, 0, 1, 127);
        issue_coords(10, 20, 12, 100);
        issue_coords(3, 0, 0, 1);
        issue_coords(40, 40, 41, 40);
        issue_coords(0, 127, 2, 0);
        issue_coords(100, 3, 90, 64);
        issue_coords(20, 100, 25, 7);
        wait_for_drain();
    endtask

    // Rows equal: the column steps
    task automatic test_col_major();
        issue_coords(0, 0, 0, 127);
        issue_coords(5, 127, 5, 0);
        issue_coords(60, 50, 60, 51);
        issue_coords(60, 51, 60, 50);
        issue_coords(127, 1, 127, 4);
        wait_for_drain();
    endtask

    // Random lines, about half of them short, with periodic drains
    task automatic test_random_lines();
        int i, kind, r1, c1, r2, c2;
        for (i = 0; i < RANDOM_LINES; i++) begin
            kind = $urandom_range(0, 99);
            r1 = $urandom_range(0, COORD_LIMIT);
            c1 = $urandom_range(0, COORD_LIMIT);
            r2 = $urandom_range(0, COORD_LIMIT);
            c2 = $urandom_range(0, COORD_LIMIT);
            if (kind < 45) begin
                r2 = near_coord(r1);
                c2 = near_coord(c1);
            end else if (kind < 55) begin
                r2 = r1;
            end else if (kind < 60) begin
                r2 = r1;
                c2 = c1;
            end else if (kind < 65) begin
                c2 = c1;
            end
            issue_coords(r1, c1, r2, c2);
            if (i % 75 == 74) wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_line  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_dots();
        test_row_major();
        test_col_major();
        test_random_lines();

        // let any stray transaction show up
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_pairs.size() != 0)
            log_failure($sformatf("%0d expected pairs never arrived", expected_pairs.size()));

        $display("Covered %0d line commands (%0d column-stepped, %0d single dots, %0d odd)",
                 lines_sent, col_major_lines, single_dot_lines, odd_lines);
        $display("Checked %0d dot pairs, longest line %0d dots, %0d failures",
                 pairs_checked, longest_line, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ilr_pkg.sv
sv/ilr_ctrl.sv
sv/ilr_dp.sv
sv/interpolated_line_rasterizer.sv
sv/ilr_checker.sv
tb/sv/tb_top.sv
